// ===== rtl/zph_pkg.sv =====
// shared constants, types and the zobrist key table for the position hash block
// no dependencies
package zph_pkg;

  localparam int HISTORY_DEPTH = 256;
  localparam int CELL_COUNT    = 61;
  localparam int MAX_EJECTED   = 6;
  localparam int DRAW_COUNT    = 3;

  localparam int HIST_AW  = $clog2(HISTORY_DEPTH);
  localparam int HIST_LW  = HIST_AW + 1;
  localparam int COUNT_W  = 9;

  localparam int KEY_BLACK_EJ = 2 * CELL_COUNT;
  localparam int KEY_WHITE_EJ = 2 * CELL_COUNT + (MAX_EJECTED + 1);
  localparam int KEY_TURN     = 2 * CELL_COUNT + 2 * (MAX_EJECTED + 1);
  localparam int KEY_COUNT    = KEY_TURN + 1;
  localparam int KEY_IDX_W    = $clog2(KEY_COUNT);

  localparam logic [63:0] MIX_ADD = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_M1  = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_M2  = 64'h94d049bb133111eb;

  localparam logic [1:0] COLOUR_BLACK = 2'd1;
  localparam logic [1:0] COLOUR_WHITE = 2'd2;

  typedef logic [63:0] key_rom_t [KEY_COUNT];

  typedef struct packed {
    logic        new_game;
    logic [63:0] hash;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // splitmix64 finalizer, only used to build the constant key table
  function automatic logic [63:0] mix64(input logic [63:0] din);
    logic [63:0] v;
    v = din + MIX_ADD;
    v = (v ^ (v >> 30)) * MIX_M1;
    v = (v ^ (v >> 27)) * MIX_M2;
    return v ^ (v >> 31);
  endfunction

  function automatic key_rom_t build_key_rom();
    key_rom_t rom;
    for (int k = 0; k < KEY_COUNT; k++) begin
      rom[k] = mix64(64'(k + 1));
    end
    return rom;
  endfunction

  localparam key_rom_t KEY_ROM = build_key_rom();

endpackage

// ===== rtl/zph_if.sv =====
// valid/ready channel interfaces for cell requests and position results
// depends on nothing
interface zph_in_if;
  logic       valid;
  logic       ready;
  logic       new_game;
  logic [5:0] cell_index;
  logic [1:0] cell_colour;
  logic       last_cell;
  logic [2:0] black_ejected;
  logic [2:0] white_ejected;
  logic       white_to_move;

  modport source (output valid, new_game, cell_index, cell_colour, last_cell,
                  black_ejected, white_ejected, white_to_move, input ready);
  modport sink (input valid, new_game, cell_index, cell_colour, last_cell,
                black_ejected, white_ejected, white_to_move, output ready);
endinterface

interface zph_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] position_hash;
  logic [63:0] history_signature;
  logic [8:0]  repeat_count;
  logic        draw;
  logic        history_full;

  modport source (output valid, position_hash, history_signature, repeat_count, draw,
                  history_full, input ready);
  modport sink (input valid, position_hash, history_signature, repeat_count, draw,
                history_full, output ready);
endinterface

// ===== rtl/zobrist_position_repetition_hash.sv =====
// top level of the zobrist position hash with threefold repetition detection
// depends on zph_pkg, zph_if, zph_front, zph_queue and zph_back
//
//   channel  dir  handshake    carries
//   in_i     in   valid/ready  one occupied-cell request, side data on the last one
//   out_o    out  valid/ready  hash, signature, repeat count, draw, history full
//
// cell requests are taken one per cycle while the queue has room
// a finished position goes through the back end as follows:
//   two splitmix64 passes on one shared 32x32 multiplier, then
//   a scan of the history memory at one entry per cycle on its single read port
// reset clears the accumulator, signature, history length and handshakes;
//   history entries hold garbage until written and are never read before that
// a stalled result sits in the output register while the back end takes the next position
module zobrist_position_repetition_hash import zph_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  zph_in_if.sink    in_i,
  zph_out_if.source out_o
);

  // front end pushes one entry per completed position
  logic     push;
  q_entry_t push_data;
  // back end pops when it is free
  logic     pop;
  q_entry_t pop_data;
  q_stat_t  q_stat;

  zph_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // small queue decouples cell intake from the slow per-position work
  zph_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (q_stat)
  );

  zph_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_data_i (pop_data),
    .q_stat_i   (q_stat),
    .pop_o      (pop),
    .out_o      (out_o)
  );

  // a push never lands on a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !q_stat.full)
    else $error("push into full queue");

  // a pop never comes from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // every reported position counts at least itself
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_o.valid |-> (out_o.repeat_count != '0))
    else $error("zero repeat count on result");

  // a push into an empty queue with no pop leaves it non-empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (push && !pop && q_stat.empty) |=> !q_stat.empty)
    else $error("queue lost an entry");

endmodule

// ===== rtl/zph_front.sv =====
// front end: takes cell requests, xors zobrist keys, emits finished position hashes
// depends on zph_pkg and zph_if
module zph_front import zph_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  zph_in_if.sink   in_i,
  input  q_stat_t  q_stat_i,
  output logic     push_o,
  output q_entry_t push_data_o
);

  logic [63:0] acc_q, acc_d;
  logic        ng_q, ng_d;
  logic        accept;
  logic [63:0] cell_key, side_key;
  logic [2:0]  b_clamp, w_clamp;

  assign in_i.ready = !q_stat_i.full;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    cell_key = '0;
    if (32'(in_i.cell_index) < CELL_COUNT) begin
      if (in_i.cell_colour == COLOUR_BLACK) begin
        cell_key = KEY_ROM[KEY_IDX_W'(in_i.cell_index)];
      end else if (in_i.cell_colour == COLOUR_WHITE) begin
        cell_key = KEY_ROM[KEY_IDX_W'(CELL_COUNT) + KEY_IDX_W'(in_i.cell_index)];
      end
    end
  end

  assign b_clamp = (32'(in_i.black_ejected) > MAX_EJECTED) ? 3'(MAX_EJECTED)
                                                           : in_i.black_ejected;
  assign w_clamp = (32'(in_i.white_ejected) > MAX_EJECTED) ? 3'(MAX_EJECTED)
                                                           : in_i.white_ejected;

  always_comb begin
    side_key = KEY_ROM[KEY_IDX_W'(KEY_BLACK_EJ) + KEY_IDX_W'(b_clamp)]
             ^ KEY_ROM[KEY_IDX_W'(KEY_WHITE_EJ) + KEY_IDX_W'(w_clamp)];
    if (in_i.white_to_move) begin
      side_key = side_key ^ KEY_ROM[KEY_IDX_W'(KEY_TURN)];
    end
  end

  assign push_o               = accept && in_i.last_cell;
  assign push_data_o.new_game = ng_q || in_i.new_game;
  assign push_data_o.hash     = acc_q ^ cell_key ^ side_key;

  always_comb begin
    acc_d = acc_q;
    ng_d  = ng_q;
    if (accept) begin
      if (in_i.last_cell) begin
        acc_d = '0;
        ng_d  = 1'b0;
      end else begin
        acc_d = acc_q ^ cell_key;
        ng_d  = ng_q || in_i.new_game;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      ng_q  <= 1'b0;
    end else begin
      acc_q <= acc_d;
      ng_q  <= ng_d;
    end
  end

endmodule

// ===== rtl/zph_queue.sv =====
// two-entry queue between the front and back ends
// depends on zph_pkg
module zph_queue import zph_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t push_data_i,
  input  logic     pop_i,
  output q_entry_t pop_data_o,
  output q_stat_t  stat_o
);

  q_entry_t   mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// ===== rtl/zph_mix.sv =====
// iterative splitmix64 finalizer on one shared 32x32 multiplier
// depends on zph_pkg
module zph_mix import zph_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] din_i,
  output logic        done_o,
  output logic [63:0] dout_o
);

  typedef enum logic [3:0] {
    MX_IDLE = 4'b0001,
    MX_P0   = 4'b0010,
    MX_P1   = 4'b0100,
    MX_P2   = 4'b1000
  } mx_state_e;

  mx_state_e   state_q, state_d;
  logic        round_q, round_d;
  logic        done_q, done_d;
  logic [63:0] v_q, v_d, acc_q, acc_d;
  logic [63:0] x, m, prod, sum;
  logic [31:0] op_a, op_b;

  assign x    = round_q ? (v_q ^ (v_q >> 27)) : (v_q ^ (v_q >> 30));
  assign m    = round_q ? MIX_M2 : MIX_M1;
  assign op_a = (state_q == MX_P1) ? x[63:32] : x[31:0];
  assign op_b = (state_q == MX_P2) ? m[63:32] : m[31:0];
  assign prod = op_a * op_b;
  assign sum  = acc_q + {prod[31:0], 32'd0};

  always_comb begin
    state_d = state_q;
    round_d = round_q;
    done_d  = 1'b0;
    v_d     = v_q;
    acc_d   = acc_q;
    unique case (state_q)
      MX_IDLE: begin
        if (start_i) begin
          v_d     = din_i + MIX_ADD;
          round_d = 1'b0;
          state_d = MX_P0;
        end
      end
      MX_P0: begin
        acc_d   = prod;
        state_d = MX_P1;
      end
      MX_P1: begin
        acc_d   = sum;
        state_d = MX_P2;
      end
      MX_P2: begin
        if (!round_q) begin
          v_d     = sum;
          round_d = 1'b1;
          state_d = MX_P0;
        end else begin
          v_d     = sum ^ (sum >> 31);
          done_d  = 1'b1;
          state_d = MX_IDLE;
        end
      end
      default: state_d = MX_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MX_IDLE;
      round_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign dout_o = v_q;

endmodule

// ===== rtl/zph_back.sv =====
// back end: signature update, history scan and append, result register
// depends on zph_pkg, zph_if and zph_mix
module zph_back import zph_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  q_entry_t pop_data_i,
  input  q_stat_t  q_stat_i,
  output logic     pop_o,
  zph_out_if.source out_o
);

  typedef enum logic [4:0] {
    BK_IDLE  = 5'b00001,
    BK_MIX_H = 5'b00010,
    BK_MIX_S = 5'b00100,
    BK_SCAN  = 5'b01000,
    BK_DONE  = 5'b10000
  } bk_state_e;

  bk_state_e          state_q, state_d;
  logic [63:0]        hash_q, hash_d, sig_q, sig_d;
  logic [HIST_LW-1:0] len_q, len_d, idx_q, idx_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic               rvalid_q, rvalid_d, full_q, full_d;
  logic               rd_en, wr_en;
  logic [63:0]        rd_q;
  logic [63:0]        hist_mem [HISTORY_DEPTH];
  logic               mix_start, mix_done;
  logic [63:0]        mix_din, mix_dout;
  logic               out_load;

  zph_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mix_start),
    .din_i   (mix_din),
    .done_o  (mix_done),
    .dout_o  (mix_dout)
  );

  assign rd_en = (state_q == BK_SCAN) && (idx_q != len_q);

  always_comb begin
    state_d   = state_q;
    hash_d    = hash_q;
    sig_d     = sig_q;
    len_d     = len_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    rvalid_d  = 1'b0;
    full_d    = full_q;
    pop_o     = 1'b0;
    mix_start = 1'b0;
    mix_din   = pop_data_i.hash;
    wr_en     = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o     = 1'b1;
          hash_d    = pop_data_i.hash;
          mix_start = 1'b1;
          if (pop_data_i.new_game) begin
            len_d = '0;
            sig_d = '0;
          end
          state_d = BK_MIX_H;
        end
      end
      BK_MIX_H: begin
        mix_din = sig_q ^ mix_dout;
        if (mix_done) begin
          mix_start = 1'b1;
          state_d   = BK_MIX_S;
        end
      end
      BK_MIX_S: begin
        if (mix_done) begin
          sig_d   = mix_dout;
          idx_d   = '0;
          cnt_d   = COUNT_W'(1);
          state_d = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (rvalid_q && (rd_q == hash_q)) begin
          cnt_d = cnt_q + COUNT_W'(1);
        end
        if (rd_en) begin
          idx_d    = idx_q + HIST_LW'(1);
          rvalid_d = 1'b1;
        end else if (!rvalid_q) begin
          full_d = (32'(len_q) == HISTORY_DEPTH);
          if (!full_d) begin
            wr_en = 1'b1;
            len_d = len_q + HIST_LW'(1);
          end
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_o.valid || out_o.ready) begin
          out_load = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hist_mem[len_q[HIST_AW-1:0]] <= hash_q;
    end
    if (rd_en) begin
      rd_q <= hist_mem[idx_q[HIST_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      sig_q       <= '0;
      len_q       <= '0;
      rvalid_q    <= 1'b0;
      out_o.valid <= 1'b0;
    end else begin
      state_q  <= state_d;
      sig_q    <= sig_d;
      len_q    <= len_d;
      rvalid_q <= rvalid_d;
      if (out_load) begin
        out_o.valid <= 1'b1;
      end else if (out_o.ready) begin
        out_o.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hash_q <= hash_d;
    idx_q  <= idx_d;
    cnt_q  <= cnt_d;
    full_q <= full_d;
    if (out_load) begin
      out_o.position_hash     <= hash_q;
      out_o.history_signature <= sig_q;
      out_o.repeat_count      <= cnt_q;
      out_o.draw              <= (32'(cnt_q) >= DRAW_COUNT);
      out_o.history_full      <= full_q;
    end
  end

endmodule
